FILE: rtl/pph_pkg.sv
// Shared types, widths, codes and fixed-point helpers for the pinhole camera block.
package pph_pkg;

  localparam int AW = 35;          // divider numerator magnitude
  localparam int BW = 32;          // divider scale factor
  localparam int DW = 36;          // divisor
  localparam int NW = 68;          // scaled numerator plus half divisor
  localparam int QW = 34;          // quotient bits kept; larger always saturates
  localparam int VW = 33;          // pose operand before translation
  localparam int OW = 34;          // pose operand after translation
  localparam int PW = 66;          // rotation product
  localparam int CW = 39;          // camera or world coordinate, unclipped
  localparam int POSE_N = 12;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_W2P  = 2'd1;
  localparam logic [1:0] REQ_P2W  = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [1:0] REG_FX = 2'd0;
  localparam logic [1:0] REG_FY = 2'd1;
  localparam logic [1:0] REG_CX = 2'd2;
  localparam logic [1:0] REG_CY = 2'd3;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef logic signed [CW-1:0] cam_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sxn;
    logic        syn;
    logic        bad;
  } side_a_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [VW-1:0] v0;
    logic [VW-1:0] v1;
    logic [VW-1:0] v2;
  } pose_in_t;

  typedef struct packed {
    logic sat;
    logic bad;
  } side_p_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
    logic        sxn;
    logic        syn;
    logic        bad;
    logic        sat;
  } side_b_t;

  // Clamp to signed 32 bits; top bit of the result flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return {1'b1, 32'h7fff_ffff};
    else if (v < -40'sd2147483648) return {1'b1, 32'h8000_0000};
    else return {1'b0, v[31:0]};
  endfunction

  // Signed quotient, with a clamped quotient standing in as 2**QW, the smallest value too wide for QW bits.
  function automatic logic signed [39:0] signed_q(input logic neg, input logic ovf,
                                                  input logic [QW-1:0] q);
    logic signed [39:0] m;
    m = ovf ? (40'sd1 <<< QW) : $signed(40'(q));
    return neg ? -m : m;
  endfunction

  // Q20.46 product to Q21.16: add half an LSB and floor.
  function automatic logic signed [PW-30:0] rnd30(input logic signed [PW-1:0] p);
    logic signed [PW-31:0] s;
    s = p[PW-1:30];
    return {s[PW-31], s} + $signed({{(PW-30){1'b0}}, p[29]});
  endfunction

endpackage

FILE: rtl/pph_div.sv
// Pipelined two-lane rounded scaled divider: q = round(a*b/d), one quotient bit per stage.
module pph_div #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [SIDE_W-1:0]     side_in,
  input  logic [pph_pkg::AW-1:0] a [0:1],
  input  logic [pph_pkg::BW-1:0] b [0:1],
  input  logic [pph_pkg::DW-1:0] d [0:1],
  output logic                  out_vld,
  output logic [SIDE_W-1:0]     side_out,
  output logic [pph_pkg::QW-1:0] q [0:1],
  output logic                  ovf [0:1]
);
  import pph_pkg::*;

  logic              vm, vh;
  logic [SIDE_W-1:0] sm, sh;
  logic [AW+BW-1:0]  pm [0:1];
  logic [DW-1:0]     dm [0:1];
  logic [DW-1:0]     dh [0:1];
  logic [NW-1:0]     nh [0:1];

  logic              vld_s  [0:QW];
  logic [SIDE_W-1:0] side_s [0:QW];
  logic [DW-1:0]     r_s    [0:QW][0:1];
  logic [QW-1:0]     lo_s   [0:QW][0:1];
  logic [QW-1:0]     q_s    [0:QW][0:1];
  logic [DW-1:0]     d_s    [0:QW][0:1];
  logic              ovf_s  [0:QW][0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      vh <= 1'b0;
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vm <= in_vld;
      vh <= vm;
      vld_s[0] <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm <= side_in;
      sh <= sm;
      side_s[0] <= sh;
      for (int l = 0; l < 2; l++) begin
        pm[l] <= (AW+BW)'(a[l]) * (AW+BW)'(b[l]);
        dm[l] <= d[l];
        nh[l] <= NW'(pm[l]) + NW'(dm[l] >> 1);
        dh[l] <= dm[l];
        // quotient needs more than QW bits: clamp
        ovf_s[0][l] <= DW'(nh[l][NW-1:QW]) >= dh[l];
        r_s[0][l]   <= DW'(nh[l][NW-1:QW]);
        lo_s[0][l]  <= nh[l][QW-1:0];
        q_s[0][l]   <= '0;
        d_s[0][l]   <= dh[l];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_iter
    logic [DW:0] tt [0:1];
    logic        ge [0:1];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        tt[l] = {r_s[k-1][l], lo_s[k-1][l][QW-1]};
        ge[l] = tt[l] >= {1'b0, d_s[k-1][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld_s[k] <= 1'b0;
      else if (en) vld_s[k] <= vld_s[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_s[k] <= side_s[k-1];
        for (int l = 0; l < 2; l++) begin
          r_s[k][l]   <= ge[l] ? DW'(tt[l] - {1'b0, d_s[k-1][l]}) : tt[l][DW-1:0];
          lo_s[k][l]  <= lo_s[k-1][l] << 1;
          q_s[k][l]   <= {q_s[k-1][l][QW-2:0], ge[l]};
          d_s[k][l]   <= d_s[k-1][l];
          ovf_s[k][l] <= ovf_s[k-1][l];
        end
      end
    end
  end

  assign out_vld  = vld_s[QW];
  assign side_out = side_s[QW];
  assign q[0]     = q_s[QW][0];
  assign q[1]     = q_s[QW][1];
  assign ovf[0]   = ovf_s[QW][0];
  assign ovf[1]   = ovf_s[QW][1];

endmodule

FILE: rtl/pph_pose.sv
// Pose store and three-stage rigid transform: forward R*p+t or inverse R^T*(c-t).
module pph_pose #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  pph_pkg::pose_in_t pin,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [1:0]        out_req,
  output logic [SIDE_W-1:0] side_out,
  output pph_pkg::cam_t     c [0:2]
);
  import pph_pkg::*;

  logic signed [31:0] pose [0:POSE_N-1];

  logic signed [31:0] rs_next [0:2][0:2];
  logic signed [31:0] t_next  [0:2];
  logic signed [OW-1:0] op_next [0:2];
  logic signed [VW-1:0] v [0:2];

  logic              v1, v2, v3;
  logic [1:0]        req1, req2, req3;
  logic [SIDE_W-1:0] s1, s2, s3;
  logic signed [31:0] rs1 [0:2][0:2];
  logic signed [31:0] t1  [0:2];
  logic signed [31:0] t2  [0:2];
  logic signed [OW-1:0] op1 [0:2];
  logic signed [PW-1:0] pr2 [0:2][0:2];
  cam_t c3 [0:2];

  assign v[0] = $signed(pin.v0);
  assign v[1] = $signed(pin.v1);
  assign v[2] = $signed(pin.v2);

  // inverse transform reads the rotation transposed
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_next[i] = pose[9+i];
      for (int j = 0; j < 3; j++)
        rs_next[i][j] = (pin.req == REQ_P2W) ? pose[3*j+i] : pose[3*i+j];
      op_next[i] = (pin.req == REQ_P2W) ? OW'(v[i]) - OW'(t_next[i]) : OW'(v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POSE_N; i++) pose[i] <= '0;
      pose[0] <= ONE_Q30;
      pose[4] <= ONE_Q30;
      pose[8] <= ONE_Q30;
    end else if (en && in_vld && pin.req == REQ_LOAD && pin.idx < 4'(POSE_N)) begin
      pose[pin.idx] <= $signed(pin.val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req1 <= pin.req;
      s1   <= side_in;
      req2 <= req1;
      s2   <= s1;
      req3 <= req2;
      s3   <= s2;
      for (int i = 0; i < 3; i++) begin
        t1[i]  <= t_next[i];
        op1[i] <= op_next[i];
        t2[i]  <= t1[i];
        for (int j = 0; j < 3; j++) begin
          rs1[i][j] <= rs_next[i][j];
          pr2[i][j] <= PW'(rs1[i][j]) * PW'(op1[j]);
        end
        c3[i] <= CW'(rnd30(pr2[i][0])) + CW'(rnd30(pr2[i][1])) + CW'(rnd30(pr2[i][2]))
                 + ((req2 == REQ_W2P) ? CW'(t2[i]) : '0);
      end
    end
  end

  assign out_vld  = v3;
  assign out_req  = req3;
  assign side_out = s3;
  assign c[0] = c3[0];
  assign c[1] = c3[1];
  assign c[2] = c3[2];

endmodule

FILE: rtl/pinhole_project_unproject.sv
// Pinhole camera top level: intrinsics registers, pipeline control and result stages.
// One item enters and one result leaves per clock unless a result sits in the output skid
// register, which holds the whole pipe. The two dividers take 37 stages each: multiply,
// add and setup, then 34 quotient stages. One divider runs before the rigid transform, for
// unprojection, and one after it, for projection. The transform adds three stages; the
// input, unprojection operand, pose operand, projection operand and result registers make
// up the rest. Pose loads take effect for every later item in order. Intrinsics are to be
// written over the register port while idle; the block itself does not enforce it.
module pinhole_project_unproject (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pph_pkg::*;

  logic [31:0] focal_x, focal_y, center_x, center_y;
  logic        en;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 32'h0001_0000;
      focal_y  <= 32'h0001_0000;
      center_x <= '0;
      center_y <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FX:  focal_x  <= pwdata;
        REG_FY:  focal_y  <= pwdata;
        REG_CX:  center_x <= pwdata;
        REG_CY:  center_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FX:  prdata = focal_x;
      REG_FY:  prdata = focal_y;
      REG_CX:  prdata = center_x;
      REG_CY:  prdata = center_y;
      default: prdata = '0;
    endcase
  end

  // input register
  logic        e_vld;
  logic [1:0]  e_req;
  logic [3:0]  e_idx;
  logic [31:0] e_val, e_x, e_y, e_z;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (en) e_vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_req <= req_type;
      e_idx <= coef_index;
      e_val <= coef_value;
      e_x   <= x_in;
      e_y   <= y_in;
      e_z   <= z_in;
    end
  end

  // offset from principal point, ahead of the unprojection divide
  logic signed [33:0] dx, dy;
  logic [31:0]        fxe, fye;
  assign dx  = $signed({{2{e_x[31]}}, e_x}) - $signed({2'b00, center_x});
  assign dy  = $signed({{2{e_y[31]}}, e_y}) - $signed({2'b00, center_y});
  assign fxe = (focal_x == '0) ? 32'd1 : focal_x;
  assign fye = (focal_y == '0) ? 32'd1 : focal_y;

  logic         p_vld;
  side_a_t      p_side;
  logic [AW-1:0] p_a [0:1];
  logic [BW-1:0] p_b [0:1];
  logic [DW-1:0] p_d [0:1];

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else if (en) p_vld <= e_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_side.req <= e_req;
      p_side.idx <= e_idx;
      p_side.val <= e_val;
      p_side.x   <= e_x;
      p_side.y   <= e_y;
      p_side.z   <= e_z;
      p_side.sxn <= dx[33];
      p_side.syn <= dy[33];
      p_side.bad <= $signed(e_z) <= 32'sd0;
      p_a[0] <= AW'(dx[33] ? -dx : dx);
      p_a[1] <= AW'(dy[33] ? -dy : dy);
      p_b[0] <= e_z;
      p_b[1] <= e_z;
      p_d[0] <= DW'(fxe);
      p_d[1] <= DW'(fye);
    end
  end

  logic         da_vld;
  side_a_t      da_side;
  logic [QW-1:0] da_q [0:1];
  logic          da_ovf [0:1];

  pph_div #(.SIDE_W($bits(side_a_t))) u_div_a (
    .clk, .rst, .en,
    .in_vld(p_vld), .side_in(p_side), .a(p_a), .b(p_b), .d(p_d),
    .out_vld(da_vld), .side_out(da_side), .q(da_q), .ovf(da_ovf)
  );

  // camera point for unprojection, or the world point for projection
  logic [32:0] cxs, cys;
  logic        unproj;
  assign cxs    = sat32(signed_q(da_side.sxn, da_ovf[0], da_q[0]));
  assign cys    = sat32(signed_q(da_side.syn, da_ovf[1], da_q[1]));
  assign unproj = da_side.req == REQ_P2W;

  logic     q_vld;
  pose_in_t q_pin;
  side_p_t  q_side;

  always_ff @(posedge clk) begin
    if (rst) q_vld <= 1'b0;
    else if (en) q_vld <= da_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q_pin.req <= da_side.req;
      q_pin.idx <= da_side.idx;
      q_pin.val <= da_side.val;
      q_pin.v0  <= unproj ? {cxs[31], cxs[31:0]} : {da_side.x[31], da_side.x};
      q_pin.v1  <= unproj ? {cys[31], cys[31:0]} : {da_side.y[31], da_side.y};
      q_pin.v2  <= {da_side.z[31], da_side.z};
      q_side.sat <= cxs[32] | cys[32];
      q_side.bad <= da_side.bad;
    end
  end

  logic       m_vld;
  logic [1:0] m_req;
  side_p_t    m_side;
  cam_t       m_c [0:2];

  pph_pose #(.SIDE_W($bits(side_p_t))) u_pose (
    .clk, .rst, .en,
    .in_vld(q_vld), .pin(q_pin), .side_in(q_side),
    .out_vld(m_vld), .out_req(m_req), .side_out(m_side), .c(m_c)
  );

  // camera point ahead of the projection divide, or the world result for unprojection
  logic [32:0] s0, s1, s2;
  logic        c0n;
  assign s0  = sat32(40'(m_c[0]));
  assign s1  = sat32(40'(m_c[1]));
  assign s2  = sat32(40'(m_c[2]));
  assign c0n = m_c[0][CW-1];

  logic          w_vld;
  side_b_t       w_side;
  logic [AW-1:0] w_a [0:1];
  logic [BW-1:0] w_b [0:1];
  logic [DW-1:0] w_d [0:1];

  always_ff @(posedge clk) begin
    if (rst) w_vld <= 1'b0;
    else if (en) w_vld <= m_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      w_side.req <= m_req;
      w_side.wx  <= s0[31:0];
      w_side.wy  <= s1[31:0];
      w_side.wz  <= s2[31:0];
      w_side.sxn <= c0n;
      w_side.syn <= m_c[1][CW-1];
      if (m_req == REQ_W2P) begin
        w_side.bad <= m_c[2] <= cam_t'(0);
        w_side.sat <= s2[32];
      end else begin
        w_side.bad <= m_side.bad;
        w_side.sat <= m_side.sat | s0[32] | s1[32] | s2[32];
      end
      w_a[0] <= AW'(c0n ? -m_c[0] : m_c[0]);
      w_a[1] <= AW'(m_c[1][CW-1] ? -m_c[1] : m_c[1]);
      w_b[0] <= focal_x;
      w_b[1] <= focal_y;
      w_d[0] <= DW'(m_c[2]);
      w_d[1] <= DW'(m_c[2]);
    end
  end

  logic          db_vld;
  side_b_t       db_side;
  logic [QW-1:0] db_q [0:1];
  logic          db_ovf [0:1];

  pph_div #(.SIDE_W($bits(side_b_t))) u_div_b (
    .clk, .rst, .en,
    .in_vld(w_vld), .side_in(w_side), .a(w_a), .b(w_b), .d(w_d),
    .out_vld(db_vld), .side_out(db_side), .q(db_q), .ovf(db_ovf)
  );

  // result stage
  logic [32:0] ux, uy;
  logic [31:0] fx_next, fy_next, fz_next;
  logic [1:0]  fst_next;
  assign ux = sat32(signed_q(db_side.sxn, db_ovf[0], db_q[0]) + $signed({8'b0, center_x}));
  assign uy = sat32(signed_q(db_side.syn, db_ovf[1], db_q[1]) + $signed({8'b0, center_y}));

  always_comb begin
    fx_next  = '0;
    fy_next  = '0;
    fz_next  = '0;
    fst_next = ST_OK;
    case (db_side.req)
      REQ_W2P: begin
        fz_next = db_side.wz;
        if (db_side.bad) begin
          fst_next = ST_BAD;
        end else begin
          fx_next  = ux[31:0];
          fy_next  = uy[31:0];
          fst_next = (db_side.sat | ux[32] | uy[32]) ? ST_SAT : ST_OK;
        end
      end
      REQ_P2W: begin
        if (db_side.bad) begin
          fst_next = ST_BAD;
        end else begin
          fx_next  = db_side.wx;
          fy_next  = db_side.wy;
          fz_next  = db_side.wz;
          fst_next = db_side.sat ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  logic        f_vld;
  logic [31:0] f_x, f_y, f_z;
  logic [1:0]  f_st;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= db_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_x  <= fx_next;
      f_y  <= fy_next;
      f_z  <= fz_next;
      f_st <= fst_next;
    end
  end

  // skid register: park the last result when the sink stalls, hold the pipe meanwhile
  logic        k_vld;
  logic [31:0] k_x, k_y, k_z;
  logic [1:0]  k_st;

  assign en       = !k_vld;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) k_vld <= 1'b0;
    else if (k_vld) k_vld <= !out_ready;
    else k_vld <= f_vld && !out_ready;
  end
  always_ff @(posedge clk) begin
    if (!k_vld) begin
      k_x  <= f_x;
      k_y  <= f_y;
      k_z  <= f_z;
      k_st <= f_st;
    end
  end

  assign out_valid = k_vld | f_vld;
  assign x_out     = k_vld ? k_x : f_x;
  assign y_out     = k_vld ? k_y : f_y;
  assign z_out     = k_vld ? k_z : f_z;
  assign status    = k_vld ? k_st : f_st;

endmodule

FILE: rtl/pph_checker.sv
// Port-level checks for the pinhole camera block, bound to the top level.
module pph_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         req_type,
  input logic [3:0]         coef_index,
  input logic signed [31:0] coef_value,
  input logic signed [31:0] x_in,
  input logic signed [31:0] y_in,
  input logic signed [31:0] z_in,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] x_out,
  input logic signed [31:0] y_out,
  input logic signed [31:0] z_out,
  input logic [1:0]         status,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);
  import pph_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD |-> x_out == '0 && y_out == '0)
    else $error("bad depth result not zeroed");

  a_ready_after_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready)
    else $error("input held after result taken");

endmodule

bind pinhole_project_unproject pph_checker u_pph_checker (.*);

FILE: verif/tb.sv
// Self-checking testbench for the pinhole camera block: table-driven directed items, then random items.
module tb;
  import pph_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code, must give an all-zero result
  localparam int LIMIT = 600000;
  localparam int DRAIN = 120;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]  req;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  st;
  } pixel_res_t;

  typedef struct {
    item_t      it;
    bit         typed;
    pixel_res_t res;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [1:0] req_type = 0;
  logic [3:0] coef_index = 0;
  logic signed [31:0] coef_value = 0, x_in = 0, y_in = 0, z_in = 0;
  logic in_ready, out_valid, pready;
  logic signed [31:0] x_out, y_out, z_out;
  logic [1:0] status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  // predictor state
  logic signed [31:0] pose_m [POSE_N];
  logic [31:0] foc_x, foc_y, ctr_x, ctr_y;
  bit clamp_hit;

  pixel_res_t results_due[$];
  bit typed_now;
  pixel_res_t typed_res;
  int send_idle, recv_idle;
  int errors = 0, n_items = 0, n_results = 0, n_bad = 0, n_sat = 0, cycles = 0;

  pinhole_project_unproject u_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic logic [31:0] clamp32(wide_t v);
    if (v > 2147483647) begin
      clamp_hit = 1;
      return 32'h7fff_ffff;
    end
    if (v < -wide_t'(64'sd2147483648)) begin
      clamp_hit = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic wide_t q30_round(wide_t v);
    return (v + (wide_t'(1) <<< 29)) >>> 30;
  endfunction

  // round(|a|*b/d) half away from zero, sign of a, magnitude capped at 2^62
  function automatic wide_t scale_div(wide_t a, logic [127:0] b, logic [127:0] d);
    logic [127:0] mag, num, q;
    mag = a < 0 ? -a : a;
    num = mag * b + (d >> 1);
    if ((num >> 64) >= d) q = 128'd1 << 62;
    else begin
      q = num / d;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
    end
    return a < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic pixel_res_t camera_model(item_t it);
    pixel_res_t r;
    wide_t p[3], c[3], d[3];
    logic [127:0] fx, fy;
    r = '{default: '0};
    clamp_hit = 0;
    for (int i = 0; i < 3; i++) p[i] = $signed(i == 0 ? it.x : i == 1 ? it.y : it.z);
    case (it.req)
      REQ_LOAD: if (it.idx < POSE_N) pose_m[it.idx] = it.val;
      REQ_W2P: begin
        for (int i = 0; i < 3; i++)
          c[i] = q30_round(wide_t'(pose_m[3*i]) * p[0]) + q30_round(wide_t'(pose_m[3*i+1]) * p[1])
                 + q30_round(wide_t'(pose_m[3*i+2]) * p[2]) + wide_t'(pose_m[9+i]);
        r.z = clamp32(c[2]);
        if (c[2] <= 0) r.st = ST_BAD;
        else begin
          r.x = clamp32(scale_div(c[0], foc_x, c[2]) + wide_t'({1'b0, ctr_x}));
          r.y = clamp32(scale_div(c[1], foc_y, c[2]) + wide_t'({1'b0, ctr_y}));
          r.st = clamp_hit ? ST_SAT : ST_OK;
        end
      end
      REQ_P2W: begin
        if (p[2] <= 0) r.st = ST_BAD;
        else begin
          // a zero focal register acts as one LSB
          fx = foc_x == 0 ? 1 : foc_x;
          fy = foc_y == 0 ? 1 : foc_y;
          c[0] = $signed(clamp32(scale_div(p[0] - wide_t'({1'b0, ctr_x}), p[2], fx)));
          c[1] = $signed(clamp32(scale_div(p[1] - wide_t'({1'b0, ctr_y}), p[2], fy)));
          c[2] = p[2];
          for (int i = 0; i < 3; i++) d[i] = c[i] - wide_t'(pose_m[9+i]);
          r.x = clamp32(q30_round(wide_t'(pose_m[0]) * d[0]) + q30_round(wide_t'(pose_m[3]) * d[1])
                        + q30_round(wide_t'(pose_m[6]) * d[2]));
          r.y = clamp32(q30_round(wide_t'(pose_m[1]) * d[0]) + q30_round(wide_t'(pose_m[4]) * d[1])
                        + q30_round(wide_t'(pose_m[7]) * d[2]));
          r.z = clamp32(q30_round(wide_t'(pose_m[2]) * d[0]) + q30_round(wide_t'(pose_m[5]) * d[1])
                        + q30_round(wide_t'(pose_m[8]) * d[2]));
          r.st = clamp_hit ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h want %h", n_results, what, got, want);
  endtask

  // accept, predict and check at the rising edge
  always @(posedge clk) begin
    pixel_res_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
    if (!rst && in_valid && in_ready) begin
      want = camera_model('{req_type, coef_index, coef_value, x_in, y_in, z_in});
      if (typed_now) want = typed_res;
      results_due.push_back(want);
      n_items++;
    end
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("unexpected result %h %h %h st %0d", x_out, y_out, z_out, status);
      end else begin
        want = results_due.pop_front();
        if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
        if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
        if (z_out !== want.z) report_mismatch("z_out", z_out, want.z);
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (want.st == ST_BAD) n_bad++;
        if (want.st == ST_SAT) n_sat++;
      end
      n_results++;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send(item_t it, bit typed, pixel_res_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    {req_type, coef_index, coef_value, x_in, y_in, z_in} = {it.req, it.idx, it.val, it.x, it.y, it.z};
    typed_now = typed;
    typed_res = res;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic reg_write(logic [1:0] which, logic [31:0] value);
    @(negedge clk);
    {psel, penable, pwrite, paddr, pwdata} = {3'b101, which, 2'b00, value};
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    {psel, penable, pwrite} = 3'b000;
    case (which)
      REG_FX: foc_x = value;
      REG_FY: foc_y = value;
      REG_CX: ctr_x = value;
      default: ctr_y = value;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (results_due.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] mixed32();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2, 3: return $urandom_range(1) ? $urandom_range(1 << 26) : -$urandom_range(1 << 26);
      default: return $urandom_range(1) ? $urandom_range(1 << 22) : -$urandom_range(1 << 22);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int k;
    it = '{REQ_W2P, 4'($urandom), $urandom, mixed32(), mixed32(), 0};
    k = $urandom_range(99);
    if (k < 14) begin
      it.req = REQ_LOAD;
      it.idx = $urandom_range(99) < 5 ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      if ($urandom_range(19) == 0) it.val = $urandom;
      else if (it.idx < 9)
        // near-identity rotation so that most projections stay in range
        it.val = ((it.idx % 4 == 0) ? ONE_Q30 : 0) + $signed($urandom_range(1 << 27)) - (1 << 26);
      else it.val = $signed($urandom_range(1 << 24)) - (1 << 23);
    end else if (k < 17) it.req = REQ_NONE;
    else begin
      it.req = k < 58 ? REQ_W2P : REQ_P2W;
      case ($urandom_range(9))
        0: it.z = $urandom;
        1: it.z = -$urandom_range(1 << 20);
        default: it.z = $urandom_range(1 << 24, 1 << 14);
      endcase
      if (it.req == REQ_P2W && $urandom_range(3) != 0) begin
        it.x = ctr_x + $urandom_range(1 << 24) - (1 << 23);
        it.y = ctr_y + $urandom_range(1 << 24) - (1 << 23);
      end
    end
    return it;
  endfunction

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) send(random_item(), 0, '{default: '0});
    drain();
  endtask

  row_t rows[$];
  pixel_res_t none;

  initial begin
    none = '{default: '0};
    foc_x = 32'h0001_0000; foc_y = 32'h0001_0000; ctr_x = 0; ctr_y = 0;
    for (int i = 0; i < POSE_N; i++) pose_m[i] = (i % 4 == 0 && i < 9) ? ONE_Q30 : 0;
    send_idle = 38; recv_idle = 63;
    rows = '{
      '{'{REQ_W2P, 0, 0, 32'h1_0000, 32'h2_0000, 32'h1_0000}, 1,
        '{32'h1_0000, 32'h2_0000, 32'h1_0000, ST_OK}},
      '{'{REQ_W2P, 0, 0, 32'h1_0000, 32'h1_0000, 0}, 1, '{0, 0, 0, ST_BAD}},
      '{'{REQ_W2P, 0, 0, 0, 0, 32'h8000_0000}, 1, '{0, 0, 32'h8000_0000, ST_BAD}},
      '{'{REQ_P2W, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff}, 1, '{0, 0, 0, ST_BAD}},
      '{'{REQ_P2W, 0, 0, 32'h3_0000, 32'hfffe_0000, 32'h2_0000}, 1,
        '{32'h6_0000, 32'hfffc_0000, 32'h2_0000, ST_OK}},
      '{'{REQ_NONE, 4'hf, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1}, 1, none},
      '{'{REQ_LOAD, 4'd13, 32'h1234_5678, 0, 0, 0}, 1, none},
      '{'{REQ_W2P, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1}, 0, none},
      '{'{REQ_P2W, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 0, none},
      '{'{REQ_W2P, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 0, none},
      '{'{REQ_LOAD, 4'd0, 32'h7fff_ffff, 0, 0, 0}, 1, none},
      '{'{REQ_LOAD, 4'd4, 32'h8000_0000, 0, 0, 0}, 1, none},
      '{'{REQ_LOAD, 4'd1, 32'h2000_0000, 0, 0, 0}, 1, none},
      '{'{REQ_LOAD, 4'd9, 32'h0010_0000, 0, 0, 0}, 1, none},
      '{'{REQ_LOAD, 4'd10, 32'hfff0_0000, 0, 0, 0}, 1, none},
      '{'{REQ_LOAD, 4'd11, 32'h8000_0000, 0, 0, 0}, 1, none},
      '{'{REQ_W2P, 0, 0, 32'h0005_0000, 32'hfffb_0000, 32'h7fff_ffff}, 0, none},
      '{'{REQ_P2W, 0, 0, 32'h0005_0000, 32'hfffb_0000, 32'h0002_8000}, 0, none},
      '{'{REQ_LOAD, 4'd11, 32'h7fff_ffff, 0, 0, 0}, 1, none},
      '{'{REQ_W2P, 0, 0, 32'h0000_8000, 32'h0001_0000, 32'h0001_0000}, 0, none},
      '{'{REQ_P2W, 0, 0, 32'hffff_8000, 32'h7fff_ffff, 32'h0000_0001}, 0, none},
      '{'{REQ_LOAD, 4'd8, 32'h0000_0001, 0, 0, 0}, 1, none},
      '{'{REQ_W2P, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000}, 0, none}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
    typed_now = 0;
    drain();

    // typical camera, receiver sparse
    reg_write(REG_FX, 32'd500 << 16);
    reg_write(REG_FY, 32'd480 << 16);
    reg_write(REG_CX, 32'd320 << 16);
    reg_write(REG_CY, 32'd240 << 16);
    random_run(440);

    // extreme intrinsics, sender sparse
    send_idle = 63; recv_idle = 38;
    reg_write(REG_FX, 32'h0);
    reg_write(REG_FY, 32'hffff_ffff);
    reg_write(REG_CX, 32'hffff_ffff);
    reg_write(REG_CY, 32'h0);
    random_run(440);

    // random intrinsics, full rate
    send_idle = 0; recv_idle = 0;
    reg_write(REG_FX, $urandom);
    reg_write(REG_FY, $urandom_range(1 << 26, 1));
    reg_write(REG_CX, $urandom);
    reg_write(REG_CY, $urandom_range(1 << 26));
    random_run(450);

    $display("covered %0d items and %0d results over four intrinsic settings", n_items, n_results);
    $display("%0d bad-depth and %0d saturated results among them", n_bad, n_sat);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
